FILE: hw/rtl/dttp_pkg.sv
// Package for the depth-truncated tree predictor: item types, commands,
// controller states and the controller/datapath command and status groups.
// No dependencies.
package dttp_pkg;

    // Table geometry follows the fixed slot fields of the item
    localparam int NODE_W       = 8;
    localparam int FEAT_W       = 4;
    localparam int DEPTH_W      = 4;
    localparam int FIELD_W      = 32;
    localparam int MAX_NODES    = 1 << NODE_W;
    localparam int NUM_FEATURES = 1 << FEAT_W;

    // Defaults for the top-level parameters
    localparam int DEF_MAX_DEPTH  = 15;
    localparam int DEF_VALUE_BITS = 32;

    // Command codes
    localparam logic [1:0] CMD_NODE_WR = 2'd0;
    localparam logic [1:0] CMD_FEAT_WR = 2'd1;
    localparam logic [1:0] CMD_QUERY   = 2'd2;

    typedef struct packed {
        logic [1:0]                command;
        logic [NODE_W-1:0]         node_index;
        logic                      leaf_flag;
        logic [NODE_W-1:0]         left_child;
        logic [NODE_W-1:0]         right_child;
        logic [FEAT_W-1:0]         split_feature;
        logic signed [FIELD_W-1:0] cut_value;
        logic [DEPTH_W-1:0]        node_depth;
        logic signed [FIELD_W-1:0] node_value;
        logic [FEAT_W-1:0]         feature_slot;
        logic signed [FIELD_W-1:0] feature_value;
        logic [DEPTH_W-1:0]        query_depth;
    } t_in_item;

    typedef struct packed {
        logic signed [FIELD_W-1:0] predicted_value;
        logic [NODE_W-1:0]         reached_node;
    } t_out_item;

    typedef enum logic {
        ST_IDLE,
        ST_WALK
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic node_wr;   // write node table entry
        logic feat_wr;   // write sample feature, walk pointer to root
        logic start;     // latch query, read node at walk pointer
        logic step;      // descend one level, read child
        logic finish;    // load result register
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic stop;      // node reached ends the walk
        logic out_valid; // result register holds an item
    } t_dp_sts;

endpackage

FILE: hw/rtl/depth_truncated_tree_predict.sv
// Top level of the depth-truncated tree predictor: controller plus datapath.
// Depends on dttp_pkg, dttp_ctrl and dttp_dp.
//
//  channel  valid        stall        payload
//  -------  -----------  -----------  ---------------------
//  input    i_in_valid   o_in_stall   i_in_item  (t_in_item)
//  output   o_out_valid  i_out_stall  o_out_item (t_out_item)
//
// Node and feature writes are taken while idle and leave the input free. A
// depth query does one node-table read and one split compare per level of
// the walk. Reset puts the walk pointer on the root and empties the result
// register; the node table and sample are not cleared. One result waits in
// the output register; writes are taken meanwhile, and a query that ends
// while that register is stalled holds until it frees.
module depth_truncated_tree_predict
    import dttp_pkg::*;
#(
    parameter int MAX_DEPTH  = DEF_MAX_DEPTH,
    parameter int VALUE_BITS = DEF_VALUE_BITS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    dttp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_command   (i_in_item.command),
        .i_out_stall (i_out_stall),
        .i_sts       (dp_sts),
        .o_in_stall  (o_in_stall),
        .o_cmd       (dp_cmd)
    );

    dttp_dp #(
        .MAX_DEPTH  (MAX_DEPTH),
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (i_in_item),
        .i_cmd       (dp_cmd),
        .i_out_stall (i_out_stall),
        .o_sts       (dp_sts),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

endmodule

FILE: hw/rtl/dttp_ctrl.sv
// Controller for the tree predictor: idle/walk state machine that issues
// datapath commands. Depends on dttp_pkg.
module dttp_ctrl
    import dttp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [1:0] i_command,
    input  logic       i_out_stall,
    input  t_dp_sts    i_sts,
    output logic       o_in_stall,
    output t_dp_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   out_free;

    // result register can take a new item this cycle
    assign out_free = !i_sts.out_valid || !i_out_stall;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid && i_command == CMD_QUERY) begin
                    n_state = ST_WALK;
                end
            end
            ST_WALK: begin
                if (i_sts.stop && out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_in_stall    = 1'b1;
        o_cmd         = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_stall    = 1'b0;
                o_cmd.node_wr = i_in_valid && i_command == CMD_NODE_WR;
                o_cmd.feat_wr = i_in_valid && i_command == CMD_FEAT_WR;
                o_cmd.start   = i_in_valid && i_command == CMD_QUERY;
            end
            ST_WALK: begin
                o_cmd.step    = !i_sts.stop;
                o_cmd.finish  = i_sts.stop && out_free;
            end
            default: o_in_stall = 1'b1;
        endcase
    end

endmodule

FILE: hw/rtl/dttp_dp.sv
// Datapath for the tree predictor: node table memory, sample registers,
// walk pointer, move counter, split compare and result register.
// Depends on dttp_pkg.
module dttp_dp
    import dttp_pkg::*;
#(
    parameter int MAX_DEPTH  = DEF_MAX_DEPTH,
    parameter int VALUE_BITS = DEF_VALUE_BITS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_item  i_item,
    input  t_dp_cmd   i_cmd,
    input  logic      i_out_stall,
    output t_dp_sts   o_sts,
    output logic      o_out_valid,
    output t_out_item o_out_item
);

    localparam int MOVE_W = $clog2(MAX_DEPTH + 1);

    typedef struct packed {
        logic                         leaf;
        logic [NODE_W-1:0]            left;
        logic [NODE_W-1:0]            right;
        logic [FEAT_W-1:0]            split;
        logic signed [VALUE_BITS-1:0] cut;
        logic [DEPTH_W-1:0]           depth;
        logic signed [VALUE_BITS-1:0] value;
    } t_node_word;

    t_node_word                   r_mem [MAX_NODES];
    t_node_word                   r_word;
    t_node_word                   wr_word;
    logic signed [VALUE_BITS-1:0] r_sample [NUM_FEATURES];
    logic [NODE_W-1:0]            r_node;
    logic [MOVE_W-1:0]            r_moves;
    logic [DEPTH_W-1:0]           r_limit;
    logic                         r_out_valid;
    t_out_item                    r_out_item;

    logic signed [VALUE_BITS-1:0] cut_v;
    logic signed [VALUE_BITS-1:0] node_v;
    logic signed [VALUE_BITS-1:0] feat_v;
    logic signed [FIELD_W-1:0]    out_v;
    logic [NODE_W-1:0]            child;
    logic [NODE_W-1:0]            rd_addr;
    logic                         go_left;

    // 32-bit fields into VALUE_BITS signed values, and back
    generate
        if (VALUE_BITS <= FIELD_W) begin : g_narrow_in
            assign cut_v  = i_item.cut_value[VALUE_BITS-1:0];
            assign node_v = i_item.node_value[VALUE_BITS-1:0];
            assign feat_v = i_item.feature_value[VALUE_BITS-1:0];
        end else begin : g_wide_in
            // upper bits read as zero
            assign cut_v  = {{(VALUE_BITS-FIELD_W){1'b0}}, i_item.cut_value};
            assign node_v = {{(VALUE_BITS-FIELD_W){1'b0}}, i_item.node_value};
            assign feat_v = {{(VALUE_BITS-FIELD_W){1'b0}}, i_item.feature_value};
        end
        if (VALUE_BITS >= FIELD_W) begin : g_wide_out
            assign out_v = r_word.value[FIELD_W-1:0];
        end else begin : g_narrow_out
            assign out_v = {{(FIELD_W-VALUE_BITS){r_word.value[VALUE_BITS-1]}},
                            r_word.value};
        end
    endgenerate

    // entry built from a node write
    always_comb begin
        wr_word.leaf  = i_item.leaf_flag;
        wr_word.left  = i_item.left_child;
        wr_word.right = i_item.right_child;
        wr_word.split = i_item.split_feature;
        wr_word.cut   = cut_v;
        wr_word.depth = i_item.node_depth;
        wr_word.value = node_v;
    end

    // split decision and walk status for the node in r_word
    assign go_left      = r_sample[r_word.split] <= r_word.cut;
    assign child        = go_left ? r_word.left : r_word.right;
    assign rd_addr      = i_cmd.step ? child : r_node;
    assign o_sts.stop   = r_word.leaf || (r_word.depth >= r_limit) ||
                          (r_moves == MOVE_W'(MAX_DEPTH));
    assign o_sts.out_valid = r_out_valid;

    // node table: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.node_wr) begin
            r_mem[i_item.node_index] <= wr_word;
        end
        if (i_cmd.start || i_cmd.step) begin
            r_word <= r_mem[rd_addr];
        end
    end

    // sample registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.feat_wr) begin
            r_sample[i_item.feature_slot] <= feat_v;
        end
    end

    // walk pointer, kept across queries of one sample
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node <= '0;
        end else if (i_cmd.feat_wr) begin
            r_node <= '0;
        end else if (i_cmd.step) begin
            r_node <= child;
        end
    end

    // query depth and move count
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_limit <= i_item.query_depth;
            r_moves <= '0;
        end else if (i_cmd.step) begin
            r_moves <= r_moves + 1'b1;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out_item.predicted_value <= out_v;
            r_out_item.reached_node    <= r_node;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

FILE: hw/rtl/dttp_checker.sv
// Port-level checker for the tree predictor, bound to the top level.
// Depends on dttp_pkg and depth_truncated_tree_predict.
module dttp_checker
    import dttp_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input t_in_item  i_in_item,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out_item
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("stalled result changed or dropped");

    // a query item starts a walk
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_in_item.command == CMD_QUERY
        |=> o_in_stall)
        else $error("query item did not start a walk");

    // write items and unused codes leave the input free in the next cycle
    a_write_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_in_item.command != CMD_QUERY
        |=> !o_in_stall)
        else $error("non-query item held the input");

    // a fresh result appears only as a walk ends
    a_result_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $fell(o_in_stall))
        else $error("result appeared outside the end of a walk");

endmodule

bind depth_truncated_tree_predict dttp_checker u_dttp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_item   (i_in_item),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);

FILE: dv/depth_truncated_tree_predict_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the depth-truncated tree predictor. Drives
// node, feature and query items and checks every answer against a built-in
// walker or a directed value. Depends on dttp_pkg and depth_truncated_tree_predict.
module depth_truncated_tree_predict_tb;
    import dttp_pkg::*;

    localparam int          WALK_LIMIT   = DEF_MAX_DEPTH;
    localparam logic [1:0]  CMD_UNUSED   = 2'd3;
    localparam int          ITEM_TARGET  = 1500;
    localparam int          HOLD_CYCLES  = 300;
    localparam int          TAIL_CYCLES  = 4 * (DEF_MAX_DEPTH + 2);
    localparam int unsigned RUN_LIMIT_NS = 5_000_000;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_stall;
    t_in_item  i_in_item   = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_item o_out_item;

    depth_truncated_tree_predict DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Shadow copy of the node table, the sample and the walk pointer
    logic [NODE_W-1:0]         tbl_left  [MAX_NODES];
    logic [NODE_W-1:0]         tbl_right [MAX_NODES];
    logic                      tbl_leaf  [MAX_NODES];
    logic [FEAT_W-1:0]         tbl_split [MAX_NODES];
    logic signed [FIELD_W-1:0] tbl_cut   [MAX_NODES];
    logic [DEPTH_W-1:0]        tbl_depth [MAX_NODES];
    logic signed [FIELD_W-1:0] tbl_value [MAX_NODES];
    logic signed [FIELD_W-1:0] sample_vals [NUM_FEATURES];
    logic [NODE_W-1:0]         walk_ptr = '0;

    t_out_item expected_answers [$];
    int        mismatches     = 0;
    int        items_sent     = 0;
    int        send_idle_pct  = 0;
    int        recv_stall_pct = 0;
    logic      hold_armed     = 1'b0;
    logic      hold_on        = 1'b0;

    typedef struct {
        t_in_item  item;
        bit        typed;
        t_out_item want;
    } t_dir_row;

    t_dir_row dir_rows [$];

    // Append to the tail of the answer queue and the directed table
    function automatic void queue_answer(input t_out_item a);
        expected_answers.insert(expected_answers.size(), a);
    endfunction

    function automatic void add_row(input t_dir_row r);
        dir_rows.insert(dir_rows.size(), r);
    endfunction

    // Apply one accepted item to the shadow state; a query yields an answer
    function automatic void predict_walk(input t_in_item it, output bit answers,
                                         output t_out_item ans);
        logic [NODE_W-1:0] node;
        bit                stop;
        answers = 1'b0;
        ans     = '0;
        case (it.command)
            CMD_NODE_WR: begin
                tbl_leaf[it.node_index]  = it.leaf_flag;
                tbl_left[it.node_index]  = it.left_child;
                tbl_right[it.node_index] = it.right_child;
                tbl_split[it.node_index] = it.split_feature;
                tbl_cut[it.node_index]   = it.cut_value;
                tbl_depth[it.node_index] = it.node_depth;
                tbl_value[it.node_index] = it.node_value;
            end
            CMD_FEAT_WR: begin
                sample_vals[it.feature_slot] = it.feature_value;
                walk_ptr = '0;
            end
            CMD_QUERY: begin
                node = walk_ptr;
                stop = 1'b0;
                // at most WALK_LIMIT moves, so cycles in the table terminate
                for (int m = 0; m < WALK_LIMIT; m++) begin
                    if (!stop) begin
                        if (tbl_leaf[node] || tbl_depth[node] >= it.query_depth)
                            stop = 1'b1;
                        else if (sample_vals[tbl_split[node]] <= tbl_cut[node])
                            node = tbl_left[node];
                        else
                            node = tbl_right[node];
                    end
                end
                walk_ptr            = node;
                answers             = 1'b1;
                ans.predicted_value = tbl_value[node];
                ans.reached_node    = node;
            end
            default: ;
        endcase
    endfunction

    // Every field random; callers overwrite what the command uses
    function automatic t_in_item rand_item();
        t_in_item it;
        it.command       = 2'($urandom_range(3));
        it.node_index    = 8'($urandom_range(255));
        it.leaf_flag     = 1'($urandom_range(1));
        it.left_child    = 8'($urandom_range(255));
        it.right_child   = 8'($urandom_range(255));
        it.split_feature = 4'($urandom_range(15));
        it.cut_value     = $urandom;
        it.node_depth    = 4'($urandom_range(15));
        it.node_value    = $urandom;
        it.feature_slot  = 4'($urandom_range(15));
        it.feature_value = $urandom;
        it.query_depth   = 4'($urandom_range(15));
        return it;
    endfunction

    // Q16.16 value, often from a small set so equal compares happen
    function automatic logic [FIELD_W-1:0] rand_q();
        logic [FIELD_W-1:0] v;
        case ($urandom_range(7))
            0: v = 32'hFFFF_FFFF;
            1: v = 32'h0000_0000;
            2: v = 32'h0000_0001;
            3: v = 32'h7FFF_FFFF;
            4: v = 32'h8000_0000;
            default: v = $urandom;
        endcase
        return v;
    endfunction

    function automatic t_in_item node_item(input logic [7:0] idx, input logic leaf,
                                           input logic [7:0] lc, input logic [7:0] rc,
                                           input logic [3:0] split,
                                           input logic [31:0] cut,
                                           input logic [3:0] depth,
                                           input logic [31:0] value);
        t_in_item it;
        it               = '0;
        it.command       = CMD_NODE_WR;
        it.node_index    = idx;
        it.leaf_flag     = leaf;
        it.left_child    = lc;
        it.right_child   = rc;
        it.split_feature = split;
        it.cut_value     = cut;
        it.node_depth    = depth;
        it.node_value    = value;
        return it;
    endfunction

    function automatic t_in_item feat_item(input logic [3:0] slot,
                                           input logic [31:0] value);
        t_in_item it;
        it               = rand_item();
        it.command       = CMD_FEAT_WR;
        it.feature_slot  = slot;
        it.feature_value = value;
        return it;
    endfunction

    function automatic t_in_item query_item(input logic [3:0] depth);
        t_in_item it;
        it             = rand_item();
        it.command     = CMD_QUERY;
        it.query_depth = depth;
        return it;
    endfunction

    // Node whose children sit a little further up the table and whose
    // depth grows with the slot, so walks go deep before stopping
    function automatic t_in_item shaped_node(input int slot, input int hop);
        t_in_item it;
        int       lc;
        int       rc;
        lc = slot + $urandom_range(1, hop);
        rc = slot + $urandom_range(1, hop);
        it               = rand_item();
        it.command       = CMD_NODE_WR;
        it.node_index    = 8'(slot);
        it.leaf_flag     = (slot == 255) || ($urandom_range(7) == 0);
        it.left_child    = 8'((lc > 255) ? 255 : lc);
        it.right_child   = 8'((rc > 255) ? 255 : rc);
        it.cut_value     = rand_q();
        it.node_depth    = 4'(slot / 17);
        return it;
    endfunction

    function automatic t_dir_row drow(input t_in_item it, input bit typed = 1'b0,
                                      input logic [31:0] value = '0,
                                      input logic [7:0] node = '0);
        t_dir_row r;
        r.item                 = it;
        r.typed                = typed;
        r.want.predicted_value = value;
        r.want.reached_node    = node;
        return r;
    endfunction

    // Offer one item and hold it until taken; then maybe go idle
    task automatic send(input t_in_item it, input bit typed = 1'b0,
                        input t_out_item want = '0);
        bit        answers;
        t_out_item ans;
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predict_walk(it, answers, ans);
        if (answers) queue_answer(typed ? want : ans);
        if (it.command != CMD_UNUSED) items_sent++;
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
    endtask

    task automatic load_tree(input int hop);
        for (int s = 0; s < MAX_NODES; s++) send(shaped_node(s, hop));
    endtask

    // One burst of random traffic, mostly a new sample and deepening queries
    task automatic run_round(input int hop);
        int       kind;
        int       depth;
        t_in_item it;
        kind = $urandom_range(99);
        if (kind < 65) begin
            repeat ($urandom_range(1, 4))
                send(feat_item(4'($urandom_range(15)), rand_q()));
            depth = $urandom_range(0, 3);
            repeat ($urandom_range(1, 6)) begin
                send(query_item(4'(depth)));
                if ($urandom_range(9) == 0) begin
                    depth = $urandom_range(15);
                end else begin
                    depth = depth + $urandom_range(0, 4);
                    if (depth > 15) depth = 15;
                end
            end
        end else if (kind < 80) begin
            repeat ($urandom_range(1, 4)) send(shaped_node($urandom_range(255), hop));
        end else if (kind < 88) begin
            // noise: malformed node or unused command
            it = rand_item();
            it.command = $urandom_range(1) ? CMD_NODE_WR : CMD_UNUSED;
            send(it);
        end else begin
            repeat ($urandom_range(1, 5)) send(query_item(4'($urandom_range(15))));
        end
    endtask

    task automatic note_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        $display("MISMATCH %s: got %h want %h", what, got, want);
        mismatches++;
    endtask

    // Receiver: take and check answers, then choose the next stall
    always @(posedge i_clk) begin : answer_check
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_answers.size() == 0) begin
                note_mismatch("unexpected answer, node",
                              32'(o_out_item.reached_node), '0);
            end else begin
                want = expected_answers.pop_front();
                if (o_out_item.predicted_value !== want.predicted_value)
                    note_mismatch("predicted_value", o_out_item.predicted_value,
                                  want.predicted_value);
                if (o_out_item.reached_node !== want.reached_node)
                    note_mismatch("reached_node", 32'(o_out_item.reached_node),
                                  32'(want.reached_node));
            end
        end
        i_out_stall <= hold_on || ($urandom_range(99) < recv_stall_pct);
    end

    // Long receiver hold-off so the block backs up into its input
    initial begin : receiver_hold_off
        wait (hold_armed);
        @(posedge i_clk);
        hold_on <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_on <= 1'b0;
    end

    initial begin : run_limit
        #(RUN_LIMIT_NS);
        $display("depth_truncated_tree_predict regression: fail");
        $finish;
    end

    initial begin : stimulus
        int hop;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Small tree: root splits on feature 3 at zero, node 2 loops on
        // itself for the right branch, node 255 is a deep leaf.
        add_row(drow(node_item(8'd0, 1'b0, 8'd1, 8'd2, 4'd3, 32'h0,
                               4'd0, 32'h7FFF_FFFF)));
        add_row(drow(node_item(8'd1, 1'b1, 8'd0, 8'd0, 4'd0, 32'h0,
                               4'd1, 32'h8000_0000)));
        add_row(drow(node_item(8'd2, 1'b0, 8'd255, 8'd2, 4'd15,
                               32'h8000_0000, 4'd1, 32'h0001_0000)));
        add_row(drow(node_item(8'd255, 1'b1, 8'd255, 8'd255, 4'd15,
                               32'h7FFF_FFFF, 4'd15, 32'h0000_0001)));
        add_row(drow(feat_item(4'd3, 32'h0)));
        add_row(drow(feat_item(4'd15, 32'h8000_0000)));
        // depth 0 stays on the root; feature equal to cut goes left
        add_row(drow(query_item(4'd0), 1'b1, 32'h7FFF_FFFF, 8'd0));
        add_row(drow(query_item(4'd1), 1'b1, 32'h8000_0000, 8'd1));
        // leaf holds; a shallower query does not move
        add_row(drow(query_item(4'd15), 1'b1, 32'h8000_0000, 8'd1));
        add_row(drow(query_item(4'd0), 1'b1, 32'h8000_0000, 8'd1));
        // unused command with every field set
        add_row(drow({CMD_UNUSED, {137{1'b1}}}));
        add_row(drow(feat_item(4'd3, 32'h0000_0001)));
        add_row(drow(query_item(4'd1), 1'b1, 32'h0001_0000, 8'd2));
        add_row(drow(query_item(4'd2), 1'b1, 32'h0000_0001, 8'd255));
        // feature above the minimum cut: node 2 loops until the move cap
        add_row(drow(feat_item(4'd15, 32'h7FFF_FFFF)));
        add_row(drow(query_item(4'd15)));
        add_row(drow(feat_item(4'd0, 32'hFFFF_FFFF)));
        add_row(drow(query_item(4'd15)));
        add_row(drow({CMD_UNUSED, {137{1'b0}}}));
        // root rewritten as a leaf at maximum depth
        add_row(drow(node_item(8'd0, 1'b1, 8'd0, 8'd0, 4'd0, 32'h0,
                               4'd15, 32'h0)));
        add_row(drow(feat_item(4'd3, 32'h0)));
        add_row(drow(query_item(4'd15), 1'b1, 32'h0, 8'd0));

        foreach (dir_rows[i]) send(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);

        // Fill the whole table and sample before any random query
        hop = $urandom_range(8, 40);
        load_tree(hop);
        for (int f = 0; f < NUM_FEATURES; f++) send(feat_item(4'(f), rand_q()));

        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin send_idle_pct = 0;  recv_stall_pct <= 0;  end
                1: begin send_idle_pct = 66; recv_stall_pct <= 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct <= 66; end
                default: begin send_idle_pct = 16; recv_stall_pct <= 16; end
            endcase
            if (p == 0) hold_armed <= 1'b1;
            if (p == 2) begin
                hop = $urandom_range(8, 40);
                load_tree(hop);
            end
            while (items_sent < (p + 1) * ITEM_TARGET / 4) run_round(hop);
        end

        // Drain, then watch a while for stray answers
        i_in_valid <= 1'b0;
        while (expected_answers.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("depth_truncated_tree_predict regression: pass");
        else
            $display("depth_truncated_tree_predict regression: fail");
        $finish;
    end

endmodule

FILE: files.f
hw/rtl/dttp_pkg.sv
hw/rtl/dttp_ctrl.sv
hw/rtl/dttp_dp.sv
hw/rtl/depth_truncated_tree_predict.sv
hw/rtl/dttp_checker.sv
dv/depth_truncated_tree_predict_tb.sv
